// ===== hw/rtl/aat_pkg.sv =====
// ----------------------------------------------------------------------------
// aat_pkg: shared definitions for the box affine transform
// Fixed-point format, register map and the reset matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int NUM_AXES  = 3;
  localparam int NUM_REGS  = 6;
  localparam int REG_W     = 64;
  localparam int ADDR_W    = 6;
  localparam int IDX_W     = 3;
  localparam int PROD_W    = 2 * DATA_W;
  // sum of three full products needs two more bits
  localparam int SUM_W     = PROD_W + 2;
  localparam int SH_W      = SUM_W - FRAC_BITS;
  localparam int ROW_W     = SH_W + 1;
  localparam int TDATA_W   = 2 * NUM_AXES * DATA_W;

  localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;

  // identity matrix, no translation
  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    {{DATA_W{1'b0}}, FIX_ONE},
    {REG_W{1'b0}},
    {FIX_ONE, {DATA_W{1'b0}}},
    {REG_W{1'b0}},
    {REG_W{1'b0}},
    {{DATA_W{1'b0}}, FIX_ONE}
  };

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aabb_affine_transform.sv =====
// ----------------------------------------------------------------------------
// aabb_affine_transform: axis-aligned box through a 3x4 affine matrix
// Returns the bounding box of the eight transformed corners, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one box per transfer (min corner, then max corner) and m_*
//   returns the transformed box. The matrix lives in six 64-bit registers on
//   the APB-style port at byte address 8*i; write it only while no box is in
//   flight. Since floor and saturation are monotone, each row's minimum and
//   maximum come from picking, per axis, the smaller and larger of the two
//   coefficient products, so no corner is enumerated.
//   Pipeline: products, per-axis min/max, three-term sum, shift/translate/
//   saturate into the output register. One box per cycle sustained while the
//   receiver holds m_tready high, set by the 18 parallel 32x32 multipliers
//   of the first stage.
//   Reset clears all stage valid bits and loads the identity matrix.
//   When the receiver stalls, each stage holds while the stage after it is
//   full; empty stages keep filling, and s_tready drops once all four hold.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_affine_transform
  import aat_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // APB-style configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [REG_W-1:0]    pwdata,
  output logic      [REG_W-1:0]    prdata,
  output logic                     pready,
  // input boxes
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [TDATA_W-1:0]  s_tdata,  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  // output boxes
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [TDATA_W-1:0]  m_tdata   // out_lo_x/y/z, out_hi_x/y/z
);

  logic [REG_W-1:0] regs [NUM_REGS];
  logic [IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign prdata  = (reg_idx < IDX_W'(NUM_REGS)) ? regs[reg_idx] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= REG_RESET[i];
    end else if (psel && penable && pwrite && pready && (reg_idx < IDX_W'(NUM_REGS))) begin
      regs[reg_idx] <= pwdata;
    end
  end

  // coefficient of row r for axis a, and translation of row r
  fix_t coef  [NUM_AXES][NUM_AXES];
  fix_t trans [NUM_AXES];
  fix_t in_lo [NUM_AXES];
  fix_t in_hi [NUM_AXES];

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      coef[r][0] = fix_t'(regs[2*r][DATA_W-1:0]);
      coef[r][1] = fix_t'(regs[2*r][REG_W-1:DATA_W]);
      coef[r][2] = fix_t'(regs[2*r+1][DATA_W-1:0]);
      trans[r]   = fix_t'(regs[2*r+1][REG_W-1:DATA_W]);
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      in_lo[a] = fix_t'(s_tdata[a*DATA_W +: DATA_W]);
      in_hi[a] = fix_t'(s_tdata[(NUM_AXES+a)*DATA_W +: DATA_W]);
    end
  end

  // floor shift, translate, saturate
  function automatic fix_t row_out(sum_t s, fix_t t);
    logic signed [SH_W-1:0]  sh;
    logic signed [ROW_W-1:0] v;
    sh = SH_W'(s >>> FRAC_BITS);
    v  = ROW_W'(sh) + ROW_W'(t);
    if (v[ROW_W-1:DATA_W-1] == {(ROW_W-DATA_W+1){v[DATA_W-1]}}) begin
      row_out = fix_t'(v[DATA_W-1:0]);
    end else if (v[ROW_W-1]) begin
      row_out = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      row_out = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // stage valid bits and advance chain
  logic vld_p, vld_m, vld_s, vld_o;
  logic adv_p, adv_m, adv_s, adv_o;

  assign adv_o    = !vld_o || m_tready;
  assign adv_s    = !vld_s || adv_o;
  assign adv_m    = !vld_m || adv_s;
  assign adv_p    = !vld_p || adv_m;
  assign s_tready = adv_p;
  assign m_tvalid = vld_o;

  prod_t prod_lo [NUM_AXES][NUM_AXES];
  prod_t prod_hi [NUM_AXES][NUM_AXES];
  prod_t term_mn [NUM_AXES][NUM_AXES];
  prod_t term_mx [NUM_AXES][NUM_AXES];
  sum_t  sum_mn  [NUM_AXES];
  sum_t  sum_mx  [NUM_AXES];
  fix_t  res_lo  [NUM_AXES];
  fix_t  res_hi  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p <= 1'b0;
      vld_m <= 1'b0;
      vld_s <= 1'b0;
      vld_o <= 1'b0;
    end else begin
      if (adv_p) vld_p <= s_tvalid;
      if (adv_m) vld_m <= vld_p;
      if (adv_s) vld_s <= vld_m;
      if (adv_o) vld_o <= vld_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_p && s_tvalid) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          prod_lo[r][a] <= PROD_W'(coef[r][a]) * PROD_W'(in_lo[a]);
          prod_hi[r][a] <= PROD_W'(coef[r][a]) * PROD_W'(in_hi[a]);
        end
      end
    end
    if (adv_m && vld_p) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          if (prod_lo[r][a] < prod_hi[r][a]) begin
            term_mn[r][a] <= prod_lo[r][a];
            term_mx[r][a] <= prod_hi[r][a];
          end else begin
            term_mn[r][a] <= prod_hi[r][a];
            term_mx[r][a] <= prod_lo[r][a];
          end
        end
      end
    end
    if (adv_s && vld_m) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        sum_mn[r] <= SUM_W'(term_mn[r][0]) + SUM_W'(term_mn[r][1]) + SUM_W'(term_mn[r][2]);
        sum_mx[r] <= SUM_W'(term_mx[r][0]) + SUM_W'(term_mx[r][1]) + SUM_W'(term_mx[r][2]);
      end
    end
    if (adv_o && vld_s) begin
      for (int r = 0; r < NUM_AXES; r++) begin
        res_lo[r] <= row_out(sum_mn[r], trans[r]);
        res_hi[r] <= row_out(sum_mx[r], trans[r]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_AXES; r++) begin
      m_tdata[r*DATA_W +: DATA_W]            = res_lo[r];
      m_tdata[(NUM_AXES+r)*DATA_W +: DATA_W] = res_hi[r];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/aat_checker.sv =====
// ----------------------------------------------------------------------------
// aat_checker: port-level checks for the box affine transform
// Watches the output stream after reset and across stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_checker
  import aat_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata
);

  // nothing is in flight right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a held result stays put
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped during stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output data changed during stall");

  // transformed box is never inverted
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      ($signed(m_tdata[0*DATA_W +: DATA_W]) <= $signed(m_tdata[3*DATA_W +: DATA_W])) &&
      ($signed(m_tdata[1*DATA_W +: DATA_W]) <= $signed(m_tdata[4*DATA_W +: DATA_W])) &&
      ($signed(m_tdata[2*DATA_W +: DATA_W]) <= $signed(m_tdata[5*DATA_W +: DATA_W])))
    else $error("output minimum above maximum");

  // input side frees up once the receiver takes the output
  a_ready_back: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready || s_tvalid)
    else $error("input stalled while output drains");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/aabb_affine_transform_test.sv =====
// ----------------------------------------------------------------------------
// aabb_affine_transform_test: self-checking bench for the box affine transform
// Streams boxes through the block under a series of matrices loaded over the
// APB port and compares every returned box, field by field, with a predicted
// bounding box of the eight transformed corners. Both stream sides idle at
// random; the matrix is reloaded only while the block is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_affine_transform_test;
  import aat_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int LATENCY          = 4;
  localparam int SETTLE_CYCLES    = 2 * LATENCY;
  localparam int TIMEOUT_CYCLES   = 400000;
  localparam int RANDOM_PER_PHASE = 80;
  localparam int MAX_PRINTS       = 40;

  typedef logic signed [SUM_W+1:0] wide_t;

  localparam fix_t  FIX_MAX = fix_t'(32'h7FFF_FFFF);
  localparam fix_t  FIX_MIN = fix_t'(32'h8000_0000);
  localparam fix_t  UNIT    = fix_t'(1) <<< FRAC_BITS;
  localparam wide_t SAT_HI  = wide_t'(FIX_MAX);
  localparam wide_t SAT_LO  = wide_t'(FIX_MIN);

  typedef enum int {
    REG_ROW0_A   = 0,
    REG_ROW0_B   = 1,
    REG_ROW1_A   = 2,
    REG_ROW1_B   = 3,
    REG_ROW2_A   = 4,
    REG_ROW2_B   = 5,
    REG_UNUSED_A = 6,
    REG_UNUSED_B = 7
  } reg_index_e;

  // lo_x in the lowest bits, hi_z in the highest
  typedef struct packed {
    fix_t hi_z;
    fix_t hi_y;
    fix_t hi_x;
    fix_t lo_z;
    fix_t lo_y;
    fix_t lo_x;
  } box_t;

  class box_scoreboard;
    logic [REG_W-1:0] matrix [NUM_REGS];
    box_t             bounds_q [$];
    int               mismatches;
    int               boxes_in;
    int               boxes_out;

    function new();
      matrix[REG_ROW0_A] = {32'h0, UNIT};
      matrix[REG_ROW0_B] = '0;
      matrix[REG_ROW1_A] = {UNIT, 32'h0};
      matrix[REG_ROW1_B] = '0;
      matrix[REG_ROW2_A] = '0;
      matrix[REG_ROW2_B] = {32'h0, UNIT};
      mismatches = 0;
      boxes_in   = 0;
      boxes_out  = 0;
    endfunction

    function void write_reg(reg_index_e idx, logic [REG_W-1:0] value);
      // writes past the last register are dropped
      if (int'(idx) < NUM_REGS) matrix[idx] = value;
    endfunction

    function int pending();
      return bounds_q.size();
    endfunction

    // floor of the exact three-term sum, plus translation, saturated
    function fix_t row_value(int r, fix_t x, fix_t y, fix_t z);
      fix_t  c0, c1, c2, offset;
      wide_t acc;
      c0     = fix_t'(matrix[2*r][DATA_W-1:0]);
      c1     = fix_t'(matrix[2*r][REG_W-1:DATA_W]);
      c2     = fix_t'(matrix[2*r+1][DATA_W-1:0]);
      offset = fix_t'(matrix[2*r+1][REG_W-1:DATA_W]);
      acc = wide_t'(c0) * wide_t'(x) + wide_t'(c1) * wide_t'(y) + wide_t'(c2) * wide_t'(z);
      acc = (acc >>> FRAC_BITS) + wide_t'(offset);
      if (acc > SAT_HI) return FIX_MAX;
      if (acc < SAT_LO) return FIX_MIN;
      return fix_t'(acc);
    endfunction

    function box_t transform_box(box_t b);
      fix_t lo [NUM_AXES];
      fix_t hi [NUM_AXES];
      fix_t pt [NUM_AXES];
      fix_t mn [NUM_AXES];
      fix_t mx [NUM_AXES];
      fix_t v;
      box_t res;
      lo = '{b.lo_x, b.lo_y, b.lo_z};
      hi = '{b.hi_x, b.hi_y, b.hi_z};
      // walk all eight corners, as given, without reordering min and max
      for (int c = 0; c < 8; c++) begin
        for (int a = 0; a < NUM_AXES; a++) pt[a] = c[a] ? hi[a] : lo[a];
        for (int r = 0; r < NUM_AXES; r++) begin
          v = row_value(r, pt[0], pt[1], pt[2]);
          if (c == 0 || v < mn[r]) mn[r] = v;
          if (c == 0 || v > mx[r]) mx[r] = v;
        end
      end
      res.lo_x = mn[0];
      res.lo_y = mn[1];
      res.lo_z = mn[2];
      res.hi_x = mx[0];
      res.hi_y = mx[1];
      res.hi_z = mx[2];
      return res;
    endfunction

    function void note_input(box_t b);
      bounds_q.push_back(transform_box(b));
      boxes_in++;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, fix_t got, fix_t want);
      if (got !== want)
        report_mismatch($sformatf("%s of box %0d: got %h, expected %h",
                                  name, boxes_out, got, want));
    endtask

    task check_output(box_t got);
      box_t want;
      if (bounds_q.size() == 0) begin
        report_mismatch($sformatf("box %h returned with none outstanding", got));
        return;
      end
      want = bounds_q.pop_front();
      compare_field("out_lo_x", got.lo_x, want.lo_x);
      compare_field("out_lo_y", got.lo_y, want.lo_y);
      compare_field("out_lo_z", got.lo_z, want.lo_z);
      compare_field("out_hi_x", got.hi_x, want.hi_x);
      compare_field("out_hi_y", got.hi_y, want.hi_y);
      compare_field("out_hi_z", got.hi_z, want.hi_z);
      boxes_out++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [REG_W-1:0]   pwdata;
  wire  [REG_W-1:0]   prdata;
  wire                pready;
  logic               s_tvalid;
  wire                s_tready;
  logic [TDATA_W-1:0] s_tdata;   // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  wire                m_tvalid;
  logic               m_tready;
  wire  [TDATA_W-1:0] m_tdata;   // out_lo_x/y/z, out_hi_x/y/z

  box_scoreboard board;
  fix_t          coef [NUM_AXES][4];
  bit            send_burst;
  int            matrices_loaded;

  aabb_affine_transform i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Run exceeded %0d cycles", TIMEOUT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_input(box_t'(s_tdata));
      if (m_tvalid && m_tready) board.check_output(box_t'(m_tdata));
    end
  end

  // result side: random stalls, with stretches of none
  initial begin : result_sink
    int stall;
    bit burst;
    burst = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 19) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic apb_write(reg_index_e idx, logic [REG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 8);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_matrix();
    for (int r = 0; r < NUM_AXES; r++) begin
      apb_write(reg_index_e'(2 * r), {coef[r][1], coef[r][0]});
      apb_write(reg_index_e'(2 * r + 1), {coef[r][3], coef[r][2]});
    end
    matrices_loaded++;
  endtask

  function automatic fix_t rand_fix(int bits);
    fix_t v;
    v = fix_t'($urandom);
    return v >>> (DATA_W - bits);
  endfunction

  task automatic fill_random(int coef_bits, int offset_bits);
    for (int r = 0; r < NUM_AXES; r++) begin
      for (int c = 0; c < 3; c++) coef[r][c] = rand_fix(coef_bits);
      coef[r][3] = rand_fix(offset_bits);
    end
  endtask

  task automatic fill_const(fix_t v);
    for (int r = 0; r < NUM_AXES; r++)
      for (int c = 0; c < 4; c++) coef[r][c] = v;
  endtask

  function automatic box_t make_box(fix_t lx, fix_t ly, fix_t lz,
                                    fix_t hx, fix_t hy, fix_t hz);
    box_t b;
    b.lo_x = lx;
    b.lo_y = ly;
    b.lo_z = lz;
    b.hi_x = hx;
    b.hi_y = hy;
    b.hi_z = hz;
    return b;
  endfunction

  function automatic fix_t rand_coord();
    case ($urandom_range(0, 3))
      0:       return rand_fix(32);
      1:       return rand_fix(24);
      2:       return rand_fix(18);
      default: return rand_fix($urandom_range(1, 32));
    endcase
  endfunction

  function automatic box_t rand_box();
    fix_t lo [NUM_AXES];
    fix_t hi [NUM_AXES];
    fix_t t;
    for (int a = 0; a < NUM_AXES; a++) begin
      lo[a] = rand_coord();
      hi[a] = rand_coord();
      // mostly well-ordered boxes, some with min above max
      if ($urandom_range(0, 3) != 0 && lo[a] > hi[a]) begin
        t     = lo[a];
        lo[a] = hi[a];
        hi[a] = t;
      end
    end
    return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic send_box(box_t b);
    int gap;
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // drop valid, wait for every outstanding box, then let the pipeline settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_directed_boxes();
    send_box(make_box('0, '0, '0, '0, '0, '0));
    send_box(make_box(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
    send_box(make_box(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
    send_box(make_box(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX));
    send_box(make_box(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN));
    send_box(make_box(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT));
    send_box(make_box(fix_t'(1), fix_t'(1), fix_t'(1), -fix_t'(1), -fix_t'(1), -fix_t'(1)));
    send_box(make_box(FIX_MAX, FIX_MIN, '0, FIX_MIN, FIX_MAX, '0));
    send_box(make_box(-7 * UNIT / 2, 9 * UNIT / 4, -100 * UNIT,
                      31 * UNIT / 4, 9 * UNIT / 4, 100 * UNIT));
    send_box(make_box(fix_t'(32'h5555_5555), fix_t'(32'hAAAA_AAAA), fix_t'(32'h5555_5555),
                      fix_t'(32'hAAAA_AAAA), fix_t'(32'h5555_5555), fix_t'(32'hAAAA_AAAA)));
    send_box(make_box(3 * UNIT, -UNIT, UNIT / 2, 3 * UNIT, -UNIT, UNIT / 2));
    send_box(make_box(FIX_MIN, '0, FIX_MAX, FIX_MAX, '0, FIX_MIN));
  endtask

  task automatic run_random_phase();
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      send_box(rand_box());
      // hold off once per phase until the pipeline is empty
      if (i == RANDOM_PER_PHASE / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin : stimulus
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    m_tready        = 1'b0;
    send_burst      = 1'b0;
    matrices_loaded = 0;
    board           = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // matrix left at its reset value
    send_directed_boxes();
    wait_drained();

    // scale, flip and push translations to both rails
    fill_const('0);
    coef[0][0] = 2 * UNIT;
    coef[0][3] = FIX_MAX;
    coef[1][1] = -2 * UNIT;
    coef[1][3] = FIX_MIN;
    coef[2][0] = UNIT / 2;
    coef[2][1] = UNIT;
    coef[2][2] = -UNIT;
    coef[2][3] = 25 * UNIT / 2;
    load_matrix();
    send_directed_boxes();
    wait_drained();

    fill_random(20, 28);
    load_matrix();
    run_random_phase();

    fill_const(FIX_MAX);
    load_matrix();
    run_random_phase();

    fill_const(FIX_MIN);
    load_matrix();
    run_random_phase();

    fill_random(32, 32);
    load_matrix();
    run_random_phase();

    // translation only; writes past the register map must not land
    fill_const('0);
    for (int r = 0; r < NUM_AXES; r++) coef[r][3] = rand_fix(32);
    load_matrix();
    apb_write(REG_UNUSED_A, {$urandom, $urandom});
    apb_write(REG_UNUSED_B, {$urandom, $urandom});
    run_random_phase();

    fill_random(17, 20);
    load_matrix();
    run_random_phase();

    $display("Streamed %0d boxes under %0d loaded matrices plus the reset one; %0d compared.",
             board.boxes_in, matrices_loaded, board.boxes_out);
    $display("Matrices ranged over identity, scale with rail translations, all-max, all-min,"
             , " full-range random, translation-only and fractional coefficients.");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
